@@ hw/rtl/swl_pkg.sv @@
// ----------------------------------------------------------------------------
// swl_pkg: shared types and constants for the stopwatch with lap store
// Event codes, run modes, time and lap formats, and the transaction
// structs that travel on the event and result channels.
// ----------------------------------------------------------------------------
package swl_pkg;

	// lap store sizing
	localparam int LAP_DEPTH = 16;
	localparam int LAP_AW    = (LAP_DEPTH > 1) ? $clog2(LAP_DEPTH) : 1;
	localparam int FILL_W    = $clog2(LAP_DEPTH + 1);

	// field widths
	localparam int FUNC_W  = 3;
	localparam int IDX_W   = 4;
	localparam int HOURS_W = 7;
	localparam int MIN_W   = 6;
	localparam int SEC_W   = 6;
	localparam int DIG_W   = 4;
	localparam int MODE_W  = 2;
	localparam int LAPS_W  = 5;
	localparam int TICK_W  = 32;
	// full hour count: 2^32 hundredths is under 12000 hours
	localparam int HOUR_W  = 14;

	// event codes
	localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_START = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PAUSE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_LAP   = 3'd4;

	// digit limits
	localparam logic [DIG_W-1:0]   DIGIT_MAX = 4'd9;
	localparam logic [SEC_W-1:0]   SEXA_MAX  = 6'd59;
	localparam logic [HOURS_W-1:0] HOUR_SAT  = 7'd99;

	typedef enum logic [MODE_W-1:0] {
		MODE_STOPPED = 2'd0,
		MODE_RUNNING = 2'd1,
		MODE_PAUSED  = 2'd2
	} mode_e;

	// displayed time, also the format of one stored lap
	typedef struct packed {
		logic [HOURS_W-1:0] hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [DIG_W-1:0]   tenths;
	} lap_t;

	// control from the event decode to the time counter
	typedef struct packed {
		logic tick;
		logic clear;
	} time_ctl_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [IDX_W-1:0]  lap_index;
	} evt_t;

	typedef struct packed {
		logic [HOURS_W-1:0] hours;
		logic [MIN_W-1:0]   minutes;
		logic [SEC_W-1:0]   seconds;
		logic [DIG_W-1:0]   tenths;
		logic [MODE_W-1:0]  run_mode;
		logic [LAPS_W-1:0]  laps_stored;
		logic               lap_valid;
		logic [HOURS_W-1:0] lap_hours;
		logic [MIN_W-1:0]   lap_minutes;
		logic [SEC_W-1:0]   lap_seconds;
		logic [DIG_W-1:0]   lap_tenths;
	} res_t;

endpackage

@@ hw/rtl/swl_time.sv @@
// ----------------------------------------------------------------------------
// swl_time: elapsed time counter
// Keeps the time as mixed-radix digits (hundredths, tenths, seconds,
// minutes, full hours) next to a binary tick count that marks the 32-bit
// wrap, so no division is needed to show the time.
// ----------------------------------------------------------------------------
module swl_time (
	input  logic             clk,
	input  logic             arst_n,
	input  swl_pkg::time_ctl_t ctl,
	output swl_pkg::lap_t    time_nx
);
	import swl_pkg::*;

	logic [TICK_W-1:0] cnt_q, cnt_d;
	logic [DIG_W-1:0]  hund_q, hund_d;
	logic [DIG_W-1:0]  tenth_q, tenth_d;
	logic [SEC_W-1:0]  sec_q, sec_d;
	logic [MIN_W-1:0]  min_q, min_d;
	logic [HOUR_W-1:0] hour_q, hour_d;
	logic              c_hund, c_tenth, c_sec, c_min;

	// carries through the digit chain
	assign c_hund  = (hund_q == DIGIT_MAX);
	assign c_tenth = c_hund && (tenth_q == DIGIT_MAX);
	assign c_sec   = c_tenth && (sec_q == SEXA_MAX);
	assign c_min   = c_sec && (min_q == SEXA_MAX);

	// next time
	always_comb begin
		cnt_d   = cnt_q;
		hund_d  = hund_q;
		tenth_d = tenth_q;
		sec_d   = sec_q;
		min_d   = min_q;
		hour_d  = hour_q;
		if (ctl.clear || (ctl.tick && (cnt_q == {TICK_W{1'b1}}))) begin
			cnt_d   = '0;
			hund_d  = '0;
			tenth_d = '0;
			sec_d   = '0;
			min_d   = '0;
			hour_d  = '0;
		end else if (ctl.tick) begin
			cnt_d   = cnt_q + TICK_W'(1);
			hund_d  = c_hund ? '0 : hund_q + DIG_W'(1);
			if (c_hund)
				tenth_d = c_tenth ? '0 : tenth_q + DIG_W'(1);
			if (c_tenth)
				sec_d = c_sec ? '0 : sec_q + SEC_W'(1);
			if (c_sec)
				min_d = c_min ? '0 : min_q + MIN_W'(1);
			if (c_min)
				hour_d = hour_q + HOUR_W'(1);
		end
	end

	// displayed time, hours held at 99
	always_comb begin
		time_nx.hours   = (hour_d > HOUR_W'(HOUR_SAT)) ? HOUR_SAT : hour_d[HOURS_W-1:0];
		time_nx.minutes = min_d;
		time_nx.seconds = sec_d;
		time_nx.tenths  = tenth_d;
	end

	// counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			hund_q  <= '0;
			tenth_q <= '0;
			sec_q   <= '0;
			min_q   <= '0;
			hour_q  <= '0;
		end else begin
			cnt_q   <= cnt_d;
			hund_q  <= hund_d;
			tenth_q <= tenth_d;
			sec_q   <= sec_d;
			min_q   <= min_d;
			hour_q  <= hour_d;
		end
	end

endmodule

@@ hw/rtl/stopwatch_with_lap_store.sv @@
// ----------------------------------------------------------------------------
// stopwatch_with_lap_store: stopwatch with lap memory
// Takes one event per transaction (tick, start, pause, clear, add lap) and
// returns the time, run mode, lap count and one selected lap after it.
// ----------------------------------------------------------------------------
//
//  channel  signals                     direction  content
//  event    evt_valid, evt_ready, evt   in         func, lap_index
//  result   res_valid, res_ready, res   out        time, mode, laps, lap view
//
// One event is taken per cycle; its result sits in the output register the
// next cycle. State updates and the result come from one level of logic
// (digit carry chain and lap store lookup) between the state registers and
// the result register. While the result register is full and not taken,
// evt_ready is low. Reset clears the time, mode, lap count and result valid;
// the lap store itself is not reset, only entries below the count are shown.
// ----------------------------------------------------------------------------
module stopwatch_with_lap_store (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          evt_valid,
	output logic          evt_ready,
	input  swl_pkg::evt_t evt,
	output logic          res_valid,
	input  logic          res_ready,
	output swl_pkg::res_t res
);
	import swl_pkg::*;

	logic              accept;
	mode_e             mode_q, mode_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic              lap_wr;
	logic [LAP_AW-1:0] wr_addr;
	logic [LAP_AW-1:0] rd_addr;
	lap_t              lap_mem_q [LAP_DEPTH];
	lap_t              time_nx;
	lap_t              lap_sel;
	logic              lap_ok;
	time_ctl_t         ctl;
	res_t              res_q;
	logic              res_valid_q;

	assign evt_ready = !res_valid_q || res_ready;
	assign accept    = evt_valid && evt_ready;
	assign wr_addr   = fill_q[LAP_AW-1:0];
	assign rd_addr   = LAP_AW'(evt.lap_index);

	// event decode
	always_comb begin
		mode_d    = mode_q;
		fill_d    = fill_q;
		lap_wr    = 1'b0;
		ctl.tick  = 1'b0;
		ctl.clear = 1'b0;
		if (accept) begin
			unique case (evt.func)
				FUNC_TICK:  ctl.tick = (mode_q == MODE_RUNNING);
				FUNC_START: mode_d = MODE_RUNNING;
				FUNC_PAUSE: mode_d = MODE_PAUSED;
				FUNC_CLEAR: begin
					ctl.clear = 1'b1;
					mode_d    = MODE_STOPPED;
					fill_d    = '0;
				end
				FUNC_LAP: begin
					if (fill_q < FILL_W'(LAP_DEPTH)) begin
						lap_wr = 1'b1;
						fill_d = fill_q + FILL_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	swl_time u_time (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.time_nx (time_nx)
	);

	// selected lap, with the lap written by this transaction forwarded
	always_comb begin
		lap_ok  = (32'(evt.lap_index) < 32'(fill_d)) && (int'(evt.lap_index) < LAP_DEPTH);
		lap_sel = (lap_wr && (rd_addr == wr_addr)) ? time_nx : lap_mem_q[rd_addr];
		if (!lap_ok)
			lap_sel = '0;
	end

	// lap store
	always_ff @(posedge clk) begin
		if (lap_wr)
			lap_mem_q[wr_addr] <= time_nx;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_STOPPED;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			mode_q <= mode_d;
			fill_q <= fill_d;
			if (accept)
				res_valid_q <= 1'b1;
			else if (res_ready)
				res_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.hours       <= time_nx.hours;
			res_q.minutes     <= time_nx.minutes;
			res_q.seconds     <= time_nx.seconds;
			res_q.tenths      <= time_nx.tenths;
			res_q.run_mode    <= mode_d;
			res_q.laps_stored <= LAPS_W'(fill_d);
			res_q.lap_valid   <= lap_ok;
			res_q.lap_hours   <= lap_sel.hours;
			res_q.lap_minutes <= lap_sel.minutes;
			res_q.lap_seconds <= lap_sel.seconds;
			res_q.lap_tenths  <= lap_sel.tenths;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
